// ===== rtl/x86sr_pkg.sv =====
// Shared command codes, width codes and the result record of the shift and rotate unit.
package x86sr_pkg;

    // Command codes as they arrive on the command field.
    localparam logic [2:0] CMD_ROL = 3'd0;
    localparam logic [2:0] CMD_ROR = 3'd1;
    localparam logic [2:0] CMD_RCL = 3'd2;
    localparam logic [2:0] CMD_RCR = 3'd3;
    localparam logic [2:0] CMD_SHL = 3'd4;
    localparam logic [2:0] CMD_SHR = 3'd5;
    localparam logic [2:0] CMD_SAL = 3'd6;
    localparam logic [2:0] CMD_SAR = 3'd7;

    // Operand width codes; the unused code behaves as 32 bits.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    // Lazy-flag kind offsets within one width group.
    localparam logic [3:0] KIND_SHL   = 4'd0;
    localparam logic [3:0] KIND_SHR   = 4'd1;
    localparam logic [3:0] KIND_SAR   = 4'd2;
    localparam logic [3:0] KIND_BASE8  = 4'd0;
    localparam logic [3:0] KIND_BASE16 = 4'd3;
    localparam logic [3:0] KIND_BASE32 = 4'd6;

    // Count moduli for the rotate-through-carry forms at 8 and 16 bits.
    localparam logic [4:0] RC_MOD9  = 5'd9;
    localparam logic [4:0] RC_MOD17 = 5'd17;

    typedef struct packed {
        logic [31:0] result_value;
        logic        flags_direct;
        logic        carry_out;
        logic        overflow_out;
        logic        lazy_valid;
        logic [3:0]  lazy_kind;
        logic [31:0] lazy_first;
        logic [4:0]  lazy_count;
        logic [31:0] lazy_result;
    } sr_result_t;

endpackage

// ===== rtl/x86sr_core.sv =====
// Combinational datapath of the shift and rotate unit: one command in, one result record out.
module x86sr_core
    import x86sr_pkg::*;
(
    input  logic [2:0]  command,
    input  logic [1:0]  width_select,
    input  logic [31:0] operand_value,
    input  logic [7:0]  shift_count,
    input  logic        carry_in,
    output sr_result_t  result
);

    always_comb
    begin
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] rep;
        logic [63:0] dbl;
        logic [63:0] dbl_l;
        logic [63:0] dbl_r;
        logic [31:0] rot_l;
        logic [31:0] rot_r;
        logic [4:0]  cnt;
        logic [4:0]  n9;
        logic [4:0]  n17;
        logic [4:0]  n_eff;
        logic [8:0]  x9;
        logic [16:0] x17;
        logic [32:0] x33;
        logic [17:0] d18_l;
        logic [17:0] d18_r;
        logic [33:0] d34_l;
        logic [33:0] d34_r;
        logic [65:0] d66_l;
        logic [65:0] d66_r;
        logic [32:0] rcl_x;
        logic [32:0] rcr_x;
        logic [31:0] rc_res;
        logic        rc_cf;
        logic [31:0] sext_v;
        logic [31:0] shl_r;
        logic [31:0] shr_r;
        logic [31:0] sar_r;
        logic [31:0] res;
        logic [31:0] res_sext;
        logic [3:0]  kind_base;
        logic        msb;
        logic        msb2;

        cnt = shift_count[4:0];

        // Width-dependent masks and the operand replicated across 32 bits, so that
        // a plain 32-bit rotate gives the rotate at the narrow width.
        case (width_select)
            WIDTH_8:
            begin
                mask      = 32'h0000_00FF;
                rep       = {4{operand_value[7:0]}};
                sext_v    = {{24{operand_value[7]}}, operand_value[7:0]};
                kind_base = KIND_BASE8;
            end
            WIDTH_16:
            begin
                mask      = 32'h0000_FFFF;
                rep       = {2{operand_value[15:0]}};
                sext_v    = {{16{operand_value[15]}}, operand_value[15:0]};
                kind_base = KIND_BASE16;
            end
            default:
            begin
                mask      = 32'hFFFF_FFFF;
                rep       = operand_value;
                sext_v    = operand_value;
                kind_base = KIND_BASE32;
            end
        endcase
        v = operand_value & mask;

        // Plain rotates.
        dbl   = {rep, rep};
        dbl_l = dbl << cnt;
        dbl_r = dbl >> cnt;
        rot_l = dbl_l[63:32] & mask;
        rot_r = dbl_r[31:0] & mask;

        // Effective counts for the rotate-through-carry forms.
        if (cnt >= 5'd27)
            n9 = cnt - 5'd27;
        else if (cnt >= 5'd18)
            n9 = cnt - 5'd18;
        else if (cnt >= RC_MOD9)
            n9 = cnt - RC_MOD9;
        else
            n9 = cnt;
        n17 = (cnt >= RC_MOD17) ? cnt - RC_MOD17 : cnt;

        x9    = {carry_in, operand_value[7:0]};
        x17   = {carry_in, operand_value[15:0]};
        x33   = {carry_in, operand_value};
        d18_l = {x9, x9} << n9;
        d18_r = {x9, x9} >> n9;
        d34_l = {x17, x17} << n17;
        d34_r = {x17, x17} >> n17;
        d66_l = {x33, x33} << cnt;
        d66_r = {x33, x33} >> cnt;

        case (width_select)
            WIDTH_8:
            begin
                n_eff = n9;
                rcl_x = {24'd0, d18_l[17:9]};
                rcr_x = {24'd0, d18_r[8:0]};
            end
            WIDTH_16:
            begin
                n_eff = n17;
                rcl_x = {16'd0, d34_l[33:17]};
                rcr_x = {16'd0, d34_r[16:0]};
            end
            default:
            begin
                n_eff = cnt;
                rcl_x = d66_l[65:33];
                rcr_x = d66_r[32:0];
            end
        endcase

        // Shifts.
        shl_r = (v << cnt) & mask;
        shr_r = v >> cnt;
        sar_r = 32'($signed(sext_v) >>> cnt) & mask;

        // Result value before flag extraction.
        case (command)
            CMD_ROL: res = rot_l;
            CMD_ROR: res = rot_r;
            CMD_RCL: res = rcl_x[31:0] & mask;
            CMD_RCR: res = rcr_x[31:0] & mask;
            CMD_SHR: res = shr_r;
            CMD_SAR: res = sar_r;
            default: res = shl_r;
        endcase

        rc_res = res;
        case (width_select)
            WIDTH_8:
            begin
                msb      = res[7];
                msb2     = res[6];
                res_sext = {{24{res[7]}}, res[7:0]};
                rc_cf    = (command == CMD_RCL) ? rcl_x[8] : rcr_x[8];
            end
            WIDTH_16:
            begin
                msb      = res[15];
                msb2     = res[14];
                res_sext = {{16{res[15]}}, res[15:0]};
                rc_cf    = (command == CMD_RCL) ? rcl_x[16] : rcr_x[16];
            end
            default:
            begin
                msb      = res[31];
                msb2     = res[30];
                res_sext = res;
                rc_cf    = (command == CMD_RCL) ? rcl_x[32] : rcr_x[32];
            end
        endcase

        result = '0;
        result.result_value = v;

        if (cnt != 5'd0)
        begin
            case (command)
                CMD_ROL:
                begin
                    result.result_value = res;
                    result.flags_direct = 1'b1;
                    result.carry_out    = res[0];
                    result.overflow_out = res[0] ^ msb;
                end
                CMD_ROR:
                begin
                    result.result_value = res;
                    result.flags_direct = 1'b1;
                    result.carry_out    = msb;
                    result.overflow_out = msb ^ msb2;
                end
                CMD_RCL, CMD_RCR:
                begin
                    // An effective count of zero leaves value and flags alone.
                    if (n_eff != 5'd0)
                    begin
                        result.result_value = rc_res;
                        result.flags_direct = 1'b1;
                        result.carry_out    = rc_cf;
                        result.overflow_out = (command == CMD_RCL) ? (rc_cf ^ msb)
                                                                    : (msb ^ msb2);
                    end
                end
                default:
                begin
                    result.result_value = res;
                    result.lazy_valid   = 1'b1;
                    result.lazy_count   = cnt;
                    result.lazy_result  = res_sext;
                    if (command == CMD_SAR)
                    begin
                        result.lazy_kind  = kind_base + KIND_SAR;
                        result.lazy_first = sext_v;
                    end
                    else if (command == CMD_SHR)
                    begin
                        result.lazy_kind  = kind_base + KIND_SHR;
                        result.lazy_first = v;
                    end
                    else
                    begin
                        result.lazy_kind  = kind_base + KIND_SHL;
                        result.lazy_first = v;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/x86_shift_rotate_unit_top.sv =====
// Top level of the x86 group-2 shift and rotate unit with its input and result registers.
//
// The unit executes one x86 group-2 command (ROL, ROR, RCL, RCR, SHL/SAL, SHR or SAR)
// per item at an operand width of 8, 16 or 32 bits. The input channel carries the
// command, width, operand, raw count and current carry; the output channel carries
// the result value, directly written carry and overflow for rotates, and a lazy-flag
// record (kind, first operand, count, sign-extended result) for shifts.
// Both channels use valid and stall: an item moves on a clock edge where valid is high
// and stall is low. The unit is a two-stage pipeline: an input register, then the
// shifter datapath, then a result register. An accepted item waits in the input register,
// passes through the datapath into the result register and is taken from there by the
// receiver; while the output is not stalled, one item can be accepted every cycle.
// The throughput of one item per cycle is set by the single barrel-shifter pass
// between the two registers.
// When the receiver stalls, the result register holds its item and the input register
// still fills, so one more item is taken before in_stall rises; in_stall is high only
// while both stages are full and the output is stalled.
// Reset (rst_n low, asynchronous) empties both stages; out_valid drops at once.
module x86_shift_rotate_unit_top
    import x86sr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  width_select,
    input  logic [31:0] operand_value,
    input  logic [7:0]  shift_count,
    input  logic        carry_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic        flags_direct,
    output logic        carry_out,
    output logic        overflow_out,
    output logic        lazy_valid,
    output logic [3:0]  lazy_kind,
    output logic [31:0] lazy_first,
    output logic [4:0]  lazy_count,
    output logic [31:0] lazy_result
);

    // Input stage registers.
    logic        s1_valid_reg;
    logic [2:0]  command_reg;
    logic [1:0]  width_select_reg;
    logic [31:0] operand_value_reg;
    logic [7:0]  shift_count_reg;
    logic        carry_in_reg;

    // Result stage registers.
    logic        out_valid_reg;
    sr_result_t  result_reg;
    sr_result_t  result_next;

    logic        adv_out;
    logic        adv_in;

    // The result stage moves when it is empty or its item is being taken; the input
    // stage moves when it is empty or can hand its item on.
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !s1_valid_reg || adv_out;
    assign in_stall = !adv_in;

    x86sr_core u_core (
        .command       (command_reg),
        .width_select  (width_select_reg),
        .operand_value (operand_value_reg),
        .shift_count   (shift_count_reg),
        .carry_in      (carry_in_reg),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                s1_valid_reg <= in_valid;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers load only when a real item moves in.
    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            command_reg       <= command;
            width_select_reg  <= width_select;
            operand_value_reg <= operand_value;
            shift_count_reg   <= shift_count;
            carry_in_reg      <= carry_in;
        end
        if (adv_out && s1_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg.result_value;
    assign flags_direct = result_reg.flags_direct;
    assign carry_out    = result_reg.carry_out;
    assign overflow_out = result_reg.overflow_out;
    assign lazy_valid   = result_reg.lazy_valid;
    assign lazy_kind    = result_reg.lazy_kind;
    assign lazy_first   = result_reg.lazy_first;
    assign lazy_count   = result_reg.lazy_count;
    assign lazy_result  = result_reg.lazy_result;

    // The input side stalls only when both stages hold an item and the output is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // An accepted item always lands in the input stage.
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item was lost from the input stage");

    // An item in the input stage reaches the result stage once it is free.
    a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv_out) |=> out_valid_reg)
        else $error("item in the input stage was not handed on");

    // A result never writes flags directly and updates the lazy record at once.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(flags_direct && lazy_valid))
        else $error("direct flags and lazy record both active");

    // Without a direct flag write, carry and overflow stay clear.
    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !flags_direct) |-> (!carry_out && !overflow_out))
        else $error("carry or overflow set without a direct flag write");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the x86 group-2 shift and rotate unit.
`timescale 1ns / 100ps

module tb;
    import x86sr_pkg::*;

    // Width codes the package leaves unnamed: 32 bits and the spare code, which acts as 32.
    localparam logic [1:0] WIDTH_32   = 2'd2;
    localparam logic [1:0] WIDTH_RSVD = 2'd3;

    // Long receiver hold-off, bound on each wait for results, and overall time limit.
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int MAX_PRINTS    = 40;

    // One row of the directed table. When typed is set, the expected result is the
    // one written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  ws;
        logic [31:0] opv;
        logic [7:0]  cnt;
        logic        cin;
        logic        typed;
        sr_result_t  res;
    } dir_row_t;

    localparam sr_result_t NO_EXP = '0;
    localparam int DIR_ROWS = 24;

    // Directed items: zero counts, counts that wrap to a full rotation, the
    // rotate-through-carry counts that reduce to nothing, shifts at or beyond the
    // width, sign fill, the spare width code, and the extreme operands and counts.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_ROL, WIDTH_8, 32'h1234_5681, 8'd0, 1'b1, 1'b1,
          '{32'h0000_0081, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_SHR, WIDTH_32, 32'hFFFF_FFFF, 8'hE0, 1'b0, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_ROL, WIDTH_8, 32'h0000_0081, 8'd1, 1'b0, 1'b0, NO_EXP},
        '{CMD_ROL, WIDTH_16, 32'h0000_8001, 8'd16, 1'b0, 1'b1,
          '{32'h0000_8001, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_ROR, WIDTH_32, 32'h8000_0001, 8'd31, 1'b0, 1'b0, NO_EXP},
        '{CMD_ROR, WIDTH_8, 32'h0000_0001, 8'd8, 1'b1, 1'b1,
          '{32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_RCL, WIDTH_8, 32'h0000_00FF, 8'd9, 1'b1, 1'b1,
          '{32'h0000_00FF, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_RCL, WIDTH_8, 32'h0000_0080, 8'd1, 1'b0, 1'b0, NO_EXP},
        '{CMD_RCR, WIDTH_16, 32'h0000_0001, 8'd17, 1'b0, 1'b1,
          '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 5'd0, 32'd0}},
        '{CMD_RCR, WIDTH_16, 32'h0000_FFFF, 8'd31, 1'b1, 1'b0, NO_EXP},
        '{CMD_RCL, WIDTH_32, 32'hFFFF_FFFF, 8'd31, 1'b0, 1'b0, NO_EXP},
        '{CMD_RCR, WIDTH_32, 32'h0000_0001, 8'd1, 1'b1, 1'b0, NO_EXP},
        '{CMD_SHL, WIDTH_32, 32'h0000_0001, 8'd31, 1'b0, 1'b1,
          '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1, KIND_BASE32 + KIND_SHL,
            32'h0000_0001, 5'd31, 32'h8000_0000}},
        '{CMD_SAL, WIDTH_8, 32'h0000_00FF, 8'd8, 1'b1, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, KIND_BASE8 + KIND_SHL,
            32'h0000_00FF, 5'd8, 32'h0000_0000}},
        '{CMD_SHR, WIDTH_16, 32'h0000_FFFF, 8'd16, 1'b0, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, KIND_BASE16 + KIND_SHR,
            32'h0000_FFFF, 5'd16, 32'h0000_0000}},
        '{CMD_SAR, WIDTH_8, 32'h0000_0080, 8'd31, 1'b0, 1'b1,
          '{32'h0000_00FF, 1'b0, 1'b0, 1'b0, 1'b1, KIND_BASE8 + KIND_SAR,
            32'hFFFF_FF80, 5'd31, 32'hFFFF_FFFF}},
        '{CMD_SAR, WIDTH_32, 32'h7FFF_FFFF, 8'd1, 1'b1, 1'b0, NO_EXP},
        '{CMD_SAR, WIDTH_16, 32'hABCD_8000, 8'd4, 1'b0, 1'b0, NO_EXP},
        '{CMD_SHL, WIDTH_16, 32'h0000_4001, 8'd1, 1'b0, 1'b0, NO_EXP},
        '{CMD_SHR, WIDTH_8, 32'hFFFF_FF80, 8'd7, 1'b1, 1'b0, NO_EXP},
        '{CMD_ROL, WIDTH_RSVD, 32'hDEAD_BEEF, 8'd4, 1'b0, 1'b0, NO_EXP},
        '{CMD_SAR, WIDTH_RSVD, 32'h8000_0000, 8'd1, 1'b0, 1'b0, NO_EXP},
        '{CMD_SHL, WIDTH_32, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, NO_EXP},
        '{CMD_RCR, WIDTH_8, 32'h0000_0000, 8'hFF, 1'b1, 1'b0, NO_EXP}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [1:0]  width_select;
    logic [31:0] operand_value;
    logic [7:0]  shift_count;
    logic        carry_in;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result_value;
    logic        flags_direct;
    logic        carry_out;
    logic        overflow_out;
    logic        lazy_valid;
    logic [3:0]  lazy_kind;
    logic [31:0] lazy_first;
    logic [4:0]  lazy_count;
    logic [31:0] lazy_result;

    // Expected results in order of acceptance, and the run's counters.
    sr_result_t pending_results [$];
    int mismatch_count = 0;
    int results_seen = 0;
    int items_sent = 0;
    int direct_flag_results = 0;
    int lazy_records = 0;
    int cmd_hits [8];
    int width_hits [4];

    // Idle rates in percent. The sender rate is used only by the stimulus process;
    // the receiver rate is written with nonblocking assignments and read at the edge.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // A toggle of hold_toggle asks the receiver process for one long hold-off.
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    sr_result_t got_res;
    sr_result_t want_res;

    x86_shift_rotate_unit_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .width_select  (width_select),
        .operand_value (operand_value),
        .shift_count   (shift_count),
        .carry_in      (carry_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .flags_direct  (flags_direct),
        .carry_out     (carry_out),
        .overflow_out  (overflow_out),
        .lazy_valid    (lazy_valid),
        .lazy_kind     (lazy_kind),
        .lazy_first    (lazy_first),
        .lazy_count    (lazy_count),
        .lazy_result   (lazy_result)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sign-extends the low w bits of v to a 64-bit pattern.
    function automatic logic [63:0] sign_from_width(input logic [63:0] v, input int unsigned w);
        logic [63:0] top;
        top = 64'd1 << (w - 1);
        return ((v & ((64'd1 << w) - 64'd1)) ^ top) - top;
    endfunction

    // Computes the full result of one command: rotated or shifted value, the
    // directly written carry and overflow of rotates, and the lazy-flag record of shifts.
    function automatic sr_result_t predict_shift_rotate(
        input logic [2:0]  cmd,
        input logic [1:0]  ws,
        input logic [31:0] opv,
        input logic [7:0]  raw_cnt,
        input logic        cin
    );
        int unsigned w;
        int unsigned rot;
        logic [4:0]  cnt;
        logic [63:0] mask;
        logic [63:0] mask1;
        logic [63:0] val;
        logic [63:0] res;
        logic [63:0] wide;
        logic [63:0] sval;
        logic [3:0]  kind;
        sr_result_t  o;
        w = (ws == WIDTH_8) ? 8 : ((ws == WIDTH_16) ? 16 : 32);
        mask = (64'd1 << w) - 64'd1;
        val = {32'd0, opv} & mask;
        cnt = raw_cnt[4:0];
        res = val;
        o = '0;
        kind = (ws == WIDTH_8) ? KIND_BASE8 : ((ws == WIDTH_16) ? KIND_BASE16 : KIND_BASE32);
        if (cnt != 5'd0)
        begin
            case (cmd)
                CMD_ROL, CMD_ROR:
                begin
                    // A count that is a multiple of the width leaves the value but
                    // still writes the flags.
                    rot = cnt & (w - 1);
                    if (rot != 0)
                    begin
                        if (cmd == CMD_ROL)
                            res = ((val << rot) | (val >> (w - rot))) & mask;
                        else
                            res = ((val >> rot) | (val << (w - rot))) & mask;
                    end
                    o.flags_direct = 1'b1;
                    if (cmd == CMD_ROL)
                    begin
                        o.carry_out = res[0];
                        o.overflow_out = res[0] ^ res[w - 1];
                    end
                    else
                    begin
                        o.carry_out = res[w - 1];
                        o.overflow_out = res[w - 1] ^ res[w - 2];
                    end
                end
                CMD_RCL, CMD_RCR:
                begin
                    if (w == 8)
                        rot = cnt % RC_MOD9;
                    else if (w == 16)
                        rot = cnt % RC_MOD17;
                    else
                        rot = cnt;
                    if (rot != 0)
                    begin
                        mask1 = (64'd1 << (w + 1)) - 64'd1;
                        wide = val | ({63'd0, cin} << w);
                        if (cmd == CMD_RCL)
                            wide = ((wide << rot) | (wide >> (w + 1 - rot))) & mask1;
                        else
                            wide = ((wide >> rot) | (wide << (w + 1 - rot))) & mask1;
                        res = wide & mask;
                        o.flags_direct = 1'b1;
                        o.carry_out = wide[w];
                        if (cmd == CMD_RCL)
                            o.overflow_out = wide[w] ^ res[w - 1];
                        else
                            o.overflow_out = res[w - 1] ^ res[w - 2];
                    end
                end
                default:
                begin
                    sval = sign_from_width(val, w);
                    if (cmd == CMD_SHR)
                    begin
                        res = val >> cnt;
                        o.lazy_first = val[31:0];
                        o.lazy_kind = kind + KIND_SHR;
                    end
                    else if (cmd == CMD_SAR)
                    begin
                        res = (sval >> cnt) & mask;
                        o.lazy_first = sval[31:0];
                        o.lazy_kind = kind + KIND_SAR;
                    end
                    else
                    begin
                        res = (val << cnt) & mask;
                        o.lazy_first = val[31:0];
                        o.lazy_kind = kind + KIND_SHL;
                    end
                    sval = sign_from_width(res, w);
                    o.lazy_valid = 1'b1;
                    o.lazy_count = cnt;
                    o.lazy_result = sval[31:0];
                end
            endcase
        end
        o.result_value = res[31:0];
        return o;
    endfunction

    // Prints one line per mismatch up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH at result %0d, %s: got %h, expected %h",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Offers one item after a random number of idle cycles, holds it until it is
    // accepted, and then queues its expected result. The valid line is lowered only
    // when an idle gap follows, so it never gets two assignments in one step.
    task automatic send_item(
        input logic [2:0]  cmd,
        input logic [1:0]  ws,
        input logic [31:0] opv,
        input logic [7:0]  cnt,
        input logic        cin,
        input logic        typed,
        input sr_result_t  typed_res
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        width_select  <= ws;
        operand_value <= opv;
        shift_count   <= cnt;
        carry_in      <= cin;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(predict_shift_rotate(cmd, ws, opv, cnt, cin));
        items_sent++;
        cmd_hits[cmd]++;
        width_hits[ws]++;
    endtask

    // Waits, within a bound, until every queued result has come back.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Receiver side: random stalls at the phase's rate, plus one long hold-off on
    // request, counted here so the sender keeps offering items meanwhile.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: each accepted result is compared field by field with the
    // oldest expectation. The outputs are sampled at the edge, before the block's
    // registers update, so the compare sees the item that moves at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            got_res = {result_value, flags_direct, carry_out, overflow_out, lazy_valid,
                       lazy_kind, lazy_first, lazy_count, lazy_result};
            if (pending_results.size() == 0)
                report_mismatch("result with no item outstanding", result_value, 32'd0);
            else
            begin
                want_res = pending_results.pop_front();
                if (want_res.flags_direct)
                    direct_flag_results++;
                if (want_res.lazy_valid)
                    lazy_records++;
                check_field("result_value", got_res.result_value, want_res.result_value);
                check_field("flags_direct", 32'(got_res.flags_direct),
                            32'(want_res.flags_direct));
                check_field("carry_out", 32'(got_res.carry_out), 32'(want_res.carry_out));
                check_field("overflow_out", 32'(got_res.overflow_out),
                            32'(want_res.overflow_out));
                check_field("lazy_valid", 32'(got_res.lazy_valid), 32'(want_res.lazy_valid));
                check_field("lazy_kind", 32'(got_res.lazy_kind), 32'(want_res.lazy_kind));
                check_field("lazy_first", got_res.lazy_first, want_res.lazy_first);
                check_field("lazy_count", 32'(got_res.lazy_count), 32'(want_res.lazy_count));
                check_field("lazy_result", got_res.lazy_result, want_res.lazy_result);
            end
        end
    end

    // Main stimulus: reset, the directed table, then four random phases with
    // different idle patterns, one long receiver hold-off and one full pause.
    initial
    begin : stimulus
        int          row;
        int          phase;
        int          n;
        int unsigned wb;
        int unsigned corner;
        logic [2:0]  r_cmd;
        logic [1:0]  r_ws;
        logic [31:0] r_opv;
        logic [7:0]  r_cnt;
        logic        r_cin;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ROL;
        width_select  = WIDTH_8;
        operand_value = 32'd0;
        shift_count   = 8'd0;
        carry_in      = 1'b0;
        for (n = 0; n < 8; n++)
            cmd_hits[n] = 0;
        for (n = 0; n < 4; n++)
            width_hits[n] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items back to back, with no stalls on either side.
        for (row = 0; row < DIR_ROWS; row++)
            send_item(DIR_TABLE[row].cmd, DIR_TABLE[row].ws, DIR_TABLE[row].opv,
                      DIR_TABLE[row].cnt, DIR_TABLE[row].cin, DIR_TABLE[row].typed,
                      DIR_TABLE[row].res);

        // Phase 0: no idling; phase 1: sender idle; phase 2: receiver stalling;
        // phase 3: both sides idle now and then.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 46;
                end
                default:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct <= 6;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // The long hold-off lands where the sender offers every cycle, so
                // both stages fill and the input stalls.
                if (phase == 0 && n == 60)
                    hold_toggle <= ~hold_toggle;
                // Pause the sender until every outstanding result has arrived. The
                // last item was just taken, so valid drops for the whole pause.
                if (phase == 1 && n == 90)
                begin
                    in_valid <= 1'b0;
                    wait_for_results();
                end

                r_cmd = 3'($urandom_range(7));
                r_ws  = ($urandom_range(19) == 0) ? WIDTH_RSVD : 2'($urandom_range(2));
                wb    = (r_ws == WIDTH_8) ? 8 : ((r_ws == WIDTH_16) ? 16 : 32);
                case ($urandom_range(5))
                    0: r_opv = 32'hFFFF_FFFF;
                    1: r_opv = (32'd1 << (wb - 1)) | 32'($urandom_range(3));
                    2: r_opv = 32'd0;
                    default: r_opv = $urandom;
                endcase
                // Half the counts sit on the corners: width boundaries, the
                // rotate-through-carry moduli and the largest masked count.
                if ($urandom_range(1) == 0)
                    r_cnt = 8'($urandom);
                else
                begin
                    case ($urandom_range(7))
                        0: corner = 0;
                        1: corner = 1;
                        2: corner = wb - 1;
                        3: corner = wb;
                        4: corner = wb + 1;
                        5: corner = RC_MOD9;
                        6: corner = RC_MOD17;
                        default: corner = 31;
                    endcase
                    r_cnt = {3'($urandom_range(7)), 5'(corner)};
                end
                r_cin = 1'($urandom_range(1));
                send_item(r_cmd, r_ws, r_opv, r_cnt, r_cin, 1'b0, NO_EXP);
            end
        end
        in_valid <= 1'b0;

        // Let everything drain, then a few more cycles to catch stray results.
        wait_for_results();
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 32'(pending_results.size()), 32'd0);
        repeat (4) @(posedge clk);

        $display("Run covered %0d items: rol %0d ror %0d rcl %0d rcr %0d shl %0d shr %0d",
                 items_sent, cmd_hits[CMD_ROL], cmd_hits[CMD_ROR], cmd_hits[CMD_RCL],
                 cmd_hits[CMD_RCR], cmd_hits[CMD_SHL], cmd_hits[CMD_SHR]);
        $display("  sal %0d sar %0d; widths 8/16/32/spare %0d/%0d/%0d/%0d; %0d %s %0d %s",
                 cmd_hits[CMD_SAL], cmd_hits[CMD_SAR], width_hits[WIDTH_8],
                 width_hits[WIDTH_16], width_hits[WIDTH_32], width_hits[WIDTH_RSVD],
                 direct_flag_results, "direct-flag results,", lazy_records,
                 "lazy-flag records");
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/x86sr_pkg.sv
rtl/x86sr_core.sv
rtl/x86_shift_rotate_unit_top.sv
verif/tb.sv
